/* rtl/psls_pkg.sv */
`default_nettype none

package psls_pkg;

    localparam int CNT_W        = 32;
    localparam int TOT_W        = 48;
    localparam int SRC_W        = 4;
    localparam int CFG_W        = 5;
    localparam int NUM_SOURCES_DEF = 16;
    localparam int DIV_STEPS    = CNT_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);
    localparam logic [CNT_W-1:0] MIN_START    = CNT_W'(1000 * 1024);
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [TOT_W-1:0] TOT_MAX      = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_WB
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] made;
        logic [CNT_W-1:0] eaten;
        logic [CNT_W-1:0] min_d;
        logic [CNT_W-1:0] max_d;
        logic [TOT_W-1:0] total;
        logic [CNT_W-1:0] avg;
    } t_row;

    localparam t_row ROW_RESET = '{
        made:  '0,
        eaten: '0,
        min_d: MIN_START,
        max_d: '0,
        total: '0,
        avg:   '0
    };

    typedef struct packed {
        logic in_stall;
        logic ram_we;
        logic out_load;
    } t_ctrl;

endpackage

`default_nettype wire

/* rtl/psls_ram.sv */
`default_nettype none

module psls_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [ADDR_W-1:0] i_waddr,
    input  wire [WIDTH-1:0]  i_wdata,
    input  wire [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/per_source_latency_statistics.sv */
// A rejected source goes from the accepted request straight to S_WB; a produced
// event passes S_READ and S_WB, a consumed one S_READ, S_DIV (the one-bit-per-cycle
// restoring divider that forms the average) and S_WB, which loads the outputs and
// waits while the receiver stalls. Requests are taken only in S_IDLE; the RAM row is
// read, updated and written back once per in-range request. Reset is synchronous,
// active low; all rows read as start values at once (per-row valid bits), no sweep.
`default_nettype none

module per_source_latency_statistics
    import psls_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [CFG_W-1:0]  i_cfg_data,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire              i_kind,
    input  wire [SRC_W-1:0]  i_source,
    input  wire [CNT_W-1:0]  i_delay,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output logic [SRC_W-1:0] o_source_echo,
    output logic [CNT_W-1:0] o_made_count,
    output logic [CNT_W-1:0] o_eaten_count,
    output logic [CNT_W-1:0] o_min_delay,
    output logic [CNT_W-1:0] o_max_delay,
    output logic [CNT_W-1:0] o_avg_delay,
    output logic             o_mismatch,
    output logic             o_index_error
);

    localparam int AW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int LIM_W = $clog2(NUM_SOURCES + 1);
    localparam int CW    = (LIM_W > CFG_W) ? LIM_W : CFG_W;
    localparam int ROW_W = $bits(t_row);

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [CFG_W-1:0]     r_active;
    logic [NUM_SOURCES-1:0] r_valid;

    logic                 r_kind;
    logic                 r_err;
    logic [SRC_W-1:0]     r_src;
    logic [AW-1:0]        r_idx;
    logic [CNT_W-1:0]     r_delay;

    t_row                 r_row;
    logic                 r_ovf;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_dvd;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [ROW_W-1:0]     ram_rdata;
    logic [AW-1:0]        ram_raddr;
    t_row                 cur_row;
    t_row                 upd_row;
    t_row                 wb_row;
    logic [CW-1:0]        limit;
    logic                 in_err;
    logic                 in_accept;
    logic [TOT_W:0]       tot_sum;
    logic [CNT_W:0]       rem_sh;
    logic                 div_ge;

    psls_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SOURCES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.ram_we),
        .i_waddr (r_idx),
        .i_wdata (wb_row),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign limit = (CW'(r_active) > CW'(NUM_SOURCES)) ? CW'(NUM_SOURCES) : CW'(r_active);
    assign in_err    = (CW'(i_source) >= limit);
    assign in_accept = i_in_valid && !ctrl.in_stall;
    // row is fetched on the accepting edge so it is ready in S_READ
    assign ram_raddr = in_accept ? AW'(i_source) : r_idx;

    // row update; rows never written read as start values
    always_comb begin
        cur_row = r_valid[r_idx] ? t_row'(ram_rdata) : ROW_RESET;
        upd_row = cur_row;
        tot_sum = {1'b0, cur_row.total} + (TOT_W + 1)'(r_delay);
        if (!r_kind) begin
            if (cur_row.made != CNT_MAX) begin
                upd_row.made = cur_row.made + CNT_W'(1);
            end
        end else begin
            if (cur_row.eaten != CNT_MAX) begin
                upd_row.eaten = cur_row.eaten + CNT_W'(1);
            end
            upd_row.total = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
            if (r_delay < cur_row.min_d) begin
                upd_row.min_d = r_delay;
            end
            if (cur_row.max_d < r_delay) begin
                upd_row.max_d = r_delay;
            end
        end
    end

    assign rem_sh = {r_rem, r_dvd[CNT_W-1]};
    assign div_ge = (rem_sh >= {1'b0, r_row.eaten});

    always_comb begin
        wb_row = r_row;
        if (r_kind) begin
            wb_row.avg = r_ovf ? CNT_MAX : r_dvd;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = in_err ? S_WB : S_READ;
                end
            end
            S_READ: begin
                n_state = r_kind ? S_DIV : S_WB;
            end
            S_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (ctrl.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                ctrl.in_stall = 1'b0;
            end
            S_WB: begin
                ctrl.in_stall = 1'b1;
                ctrl.out_load = !o_out_valid || !i_out_stall;
                ctrl.ram_we   = ctrl.out_load && !r_err;
            end
            default: begin
                ctrl.in_stall = 1'b1;
            end
        endcase
    end

    assign o_in_stall = ctrl.in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACTIVE_RESET;
            r_valid     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (ctrl.ram_we) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (ctrl.out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_kind;
            r_err   <= in_err;
            r_src   <= i_source;
            r_idx   <= AW'(i_source);
            r_delay <= i_delay;
        end
        if (r_state == S_READ) begin
            r_row <= upd_row;
            r_rem <= CNT_W'(upd_row.total[TOT_W-1:CNT_W]);
            r_dvd <= upd_row.total[CNT_W-1:0];
            r_ovf <= (CNT_W'(upd_row.total[TOT_W-1:CNT_W]) >= upd_row.eaten);
            r_cnt <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem <= div_ge ? CNT_W'(rem_sh - {1'b0, r_row.eaten}) : rem_sh[CNT_W-1:0];
            r_dvd <= {r_dvd[CNT_W-2:0], div_ge};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
        if (ctrl.out_load) begin
            o_source_echo <= r_src;
            o_index_error <= r_err;
            if (r_err) begin
                o_made_count  <= '0;
                o_eaten_count <= '0;
                o_min_delay   <= '0;
                o_max_delay   <= '0;
                o_avg_delay   <= '0;
                o_mismatch    <= 1'b0;
            end else begin
                o_made_count  <= wb_row.made;
                o_eaten_count <= wb_row.eaten;
                o_min_delay   <= wb_row.min_d;
                o_max_delay   <= wb_row.max_d;
                o_avg_delay   <= wb_row.avg;
                o_mismatch    <= (wb_row.made != wb_row.eaten);
            end
        end
    end

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> o_made_count == '0 && o_eaten_count == '0
            && o_avg_delay == '0 && !o_mismatch)
        else $error("rejected request carries statistics");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_index_error && o_eaten_count != '0
            |-> o_min_delay <= o_max_delay)
        else $error("min above max after a consume");

    a_we_in_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ram_we |-> r_state == S_WB && !r_err)
        else $error("RAM written outside write-back");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |=> r_state == S_DIV || r_state == S_WB)
        else $error("divider left early");

    a_read_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> $past(r_state) == S_IDLE && !r_err)
        else $error("read without accepted request");
`endif

endmodule

`default_nettype wire

/* test/tb_per_source_latency_statistics.sv */
module tb_per_source_latency_statistics;
    import psls_pkg::*;

    localparam bit KIND_MADE  = 1'b0;
    localparam bit KIND_EATEN = 1'b1;
    localparam int N_PHASES   = 8;

    typedef enum logic {ROW_EVENT, ROW_CFG} t_row_op;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [CNT_W-1:0] made;
        logic [CNT_W-1:0] eaten;
        logic [CNT_W-1:0] min_d;
        logic [CNT_W-1:0] max_d;
        logic [CNT_W-1:0] avg;
        logic             mism;
        logic             err;
    } t_stat_result;

    typedef struct packed {
        t_row_op          op;
        logic             kind;
        logic [SRC_W-1:0] src;
        logic [CNT_W-1:0] delay;
        logic [CFG_W-1:0] cfg;
        logic             typed;
        t_stat_result     want;
    } t_script_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_kind = 1'b0;
    logic [SRC_W-1:0] i_source = '0;
    logic [CNT_W-1:0] i_delay = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [SRC_W-1:0] o_source_echo;
    logic [CNT_W-1:0] o_made_count;
    logic [CNT_W-1:0] o_eaten_count;
    logic [CNT_W-1:0] o_min_delay;
    logic [CNT_W-1:0] o_max_delay;
    logic [CNT_W-1:0] o_avg_delay;
    logic             o_mismatch;
    logic             o_index_error;

    per_source_latency_statistics DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_source      (i_source),
        .i_delay       (i_delay),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_source_echo (o_source_echo),
        .o_made_count  (o_made_count),
        .o_eaten_count (o_eaten_count),
        .o_min_delay   (o_min_delay),
        .o_max_delay   (o_max_delay),
        .o_avg_delay   (o_avg_delay),
        .o_mismatch    (o_mismatch),
        .o_index_error (o_index_error)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the statistics rows
    logic [CFG_W-1:0] active_srcs;
    logic [CNT_W-1:0] made_cnt  [NUM_SOURCES_DEF];
    logic [CNT_W-1:0] eaten_cnt [NUM_SOURCES_DEF];
    logic [CNT_W-1:0] min_seen  [NUM_SOURCES_DEF];
    logic [CNT_W-1:0] max_seen  [NUM_SOURCES_DEF];
    logic [TOT_W-1:0] delay_sum [NUM_SOURCES_DEF];
    logic [CNT_W-1:0] avg_seen  [NUM_SOURCES_DEF];

    t_stat_result expected_stats [$];

    int error_count   = 0;
    int results_seen  = 0;
    int produced_reqs = 0;
    int consumed_reqs = 0;
    int rejected_reqs = 0;
    int cfg_writes    = 0;

    function automatic t_stat_result update_source_stats(logic kind, logic [SRC_W-1:0] src,
                                                         logic [CNT_W-1:0] delay);
        t_stat_result r;
        logic [CFG_W-1:0] lim;
        logic [63:0] quot;
        r = '0;
        r.src = src;
        lim = (active_srcs > NUM_SOURCES_DEF) ? CFG_W'(NUM_SOURCES_DEF) : active_srcs;
        if (CFG_W'(src) >= lim) begin
            r.err = 1'b1;
            return r;
        end
        if (kind == KIND_MADE) begin
            if (made_cnt[src] != CNT_MAX) made_cnt[src] = made_cnt[src] + 1;
        end else begin
            if (eaten_cnt[src] != CNT_MAX) eaten_cnt[src] = eaten_cnt[src] + 1;
            if (TOT_MAX - delay_sum[src] < TOT_W'(delay)) delay_sum[src] = TOT_MAX;
            else delay_sum[src] = delay_sum[src] + TOT_W'(delay);
            if (delay < min_seen[src]) min_seen[src] = delay;
            if (max_seen[src] < delay) max_seen[src] = delay;
            quot = 64'(delay_sum[src]) / 64'(eaten_cnt[src]);
            avg_seen[src] = (quot > 64'(CNT_MAX)) ? CNT_MAX : quot[CNT_W-1:0];
        end
        r.made  = made_cnt[src];
        r.eaten = eaten_cnt[src];
        r.min_d = min_seen[src];
        r.max_d = max_seen[src];
        r.avg   = avg_seen[src];
        r.mism  = (made_cnt[src] != eaten_cnt[src]);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        error_count++;
        if (error_count <= 40)
            $display("ERROR %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task automatic check_field(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // result side: compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_stat_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_stats.size() == 0) begin
                report_mismatch("result with nothing pending, source", CNT_W'(o_source_echo), '0);
            end else begin
                want = expected_stats.pop_front();
                check_field("source_echo", CNT_W'(o_source_echo), CNT_W'(want.src));
                check_field("made_count", o_made_count, want.made);
                check_field("eaten_count", o_eaten_count, want.eaten);
                check_field("min_delay", o_min_delay, want.min_d);
                check_field("max_delay", o_max_delay, want.max_d);
                check_field("avg_delay", o_avg_delay, want.avg);
                check_field("mismatch", CNT_W'(o_mismatch), CNT_W'(want.mism));
                check_field("index_error", CNT_W'(o_index_error), CNT_W'(want.err));
            end
        end
    end

    // receiver stall pattern: free-running, random, or long on/off runs
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_run = 0;
    bit rx_hold = 1'b0;

    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(100, 600);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (rx_run == 0) begin
                    rx_hold = !rx_hold;
                    rx_run = $urandom_range(1, 12);
                end else begin
                    rx_run--;
                end
                i_out_stall <= rx_hold;
            end
        endcase
    end

    task automatic push_request(logic kind, logic [SRC_W-1:0] src, logic [CNT_W-1:0] delay,
                                logic typed, t_stat_result typed_want);
        t_stat_result pred;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_source   <= src;
        i_delay    <= delay;
        do @(posedge i_clk); while (o_in_stall);
        pred = update_source_stats(kind, src, delay);
        expected_stats.push_back(typed ? typed_want : pred);
        if (pred.err) rejected_reqs++;
        else if (kind == KIND_EATEN) consumed_reqs++;
        else produced_reqs++;
    endtask

    task automatic sender_gap(int n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_active(logic [CFG_W-1:0] val);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        active_srcs = val;
        cfg_writes++;
    endtask

    t_script_row script_rows [0:21] = '{
        '{ROW_EVENT, KIND_MADE,  4'd0,  32'd0,          5'd0, 1'b1,
          '{4'd0,  32'd1, 32'd0, MIN_START, 32'd0, 32'd0, 1'b1, 1'b0}},
        '{ROW_EVENT, KIND_EATEN, 4'd0,  32'd0,          5'd0, 1'b1,
          '{4'd0,  32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{ROW_EVENT, KIND_EATEN, 4'd0,  32'hFFFF_FFFF,  5'd0, 1'b1,
          '{4'd0,  32'd1, 32'd2, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0}},
        // equal to the start minimum: strict compare keeps it
        '{ROW_EVENT, KIND_EATEN, 4'd15, MIN_START,      5'd0, 1'b1,
          '{4'd15, 32'd0, 32'd1, MIN_START, MIN_START, MIN_START, 1'b1, 1'b0}},
        '{ROW_EVENT, KIND_EATEN, 4'd15, MIN_START - 1,  5'd0, 1'b0, '0},
        '{ROW_EVENT, KIND_MADE,  4'd15, 32'hFFFF_FFFF,  5'd0, 1'b0, '0},
        '{ROW_EVENT, KIND_MADE,  4'd15, 32'd0,          5'd0, 1'b0, '0},
        '{ROW_EVENT, KIND_EATEN, 4'd7,  32'd1,          5'd0, 1'b0, '0},
        '{ROW_EVENT, KIND_EATEN, 4'd7,  32'h5555_5555,  5'd0, 1'b0, '0},
        '{ROW_EVENT, KIND_EATEN, 4'd7,  32'hAAAA_AAAA,  5'd0, 1'b0, '0},
        '{ROW_EVENT, KIND_EATEN, 4'd7,  MIN_START + 1,  5'd0, 1'b0, '0},
        '{ROW_CFG,   KIND_MADE,  4'd0,  32'd0,          5'd1, 1'b0, '0},
        '{ROW_EVENT, KIND_MADE,  4'd1,  32'd0,          5'd0, 1'b1,
          '{4'd1,  32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{ROW_EVENT, KIND_EATEN, 4'd15, 32'd123,        5'd0, 1'b1,
          '{4'd15, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{ROW_EVENT, KIND_MADE,  4'd0,  32'd0,          5'd0, 1'b0, '0},
        '{ROW_CFG,   KIND_MADE,  4'd0,  32'd0,          5'd0, 1'b0, '0},
        '{ROW_EVENT, KIND_MADE,  4'd0,  32'd0,          5'd0, 1'b1,
          '{4'd0,  32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{ROW_CFG,   KIND_MADE,  4'd0,  32'd0,          5'd31, 1'b0, '0},
        '{ROW_EVENT, KIND_EATEN, 4'd15, 32'hFFFF_FFFF,  5'd0, 1'b0, '0},
        '{ROW_EVENT, KIND_MADE,  4'd3,  32'd77,         5'd0, 1'b0, '0},
        '{ROW_CFG,   KIND_MADE,  4'd0,  32'd0,          5'd16, 1'b0, '0},
        '{ROW_EVENT, KIND_EATEN, 4'd8,  32'd0,          5'd0, 1'b0, '0}
    };

    logic [CFG_W-1:0] phase_cfg [0:N_PHASES-1] = '{5'd16, 5'd31, 5'd1, 5'd0,
                                                   5'd5, 5'd16, 5'd9, 5'd3};
    int phase_len [0:N_PHASES-1] = '{260, 260, 200, 60, 260, 300, 260, 300};

    initial begin
        int burst_left;
        int lim;
        logic kind;
        logic [SRC_W-1:0] src;
        logic [CNT_W-1:0] delay;

        active_srcs = ACTIVE_RESET;
        for (int s = 0; s < NUM_SOURCES_DEF; s++) begin
            made_cnt[s]  = '0;
            eaten_cnt[s] = '0;
            min_seen[s]  = MIN_START;
            max_seen[s]  = '0;
            delay_sum[s] = '0;
            avg_seen[s]  = '0;
        end
        phase_cfg[4] = CFG_W'($urandom_range(2, 15));
        phase_cfg[6] = CFG_W'($urandom_range(0, 31));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_rows[r]) begin
            if (script_rows[r].op == ROW_CFG)
                write_active(script_rows[r].cfg);
            else
                push_request(script_rows[r].kind, script_rows[r].src, script_rows[r].delay,
                             script_rows[r].typed, script_rows[r].want);
        end

        burst_left = 0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_active(phase_cfg[ph]);
            lim = (phase_cfg[ph] > NUM_SOURCES_DEF) ? NUM_SOURCES_DEF : int'(phase_cfg[ph]);
            for (int n = 0; n < phase_len[ph]; n++) begin
                if (burst_left == 0) begin
                    sender_gap($urandom_range(1, 10));
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                              : $urandom_range(1, 12);
                end
                burst_left--;
                if ($urandom_range(0, 299) == 0) drain_results();
                kind = 1'($urandom_range(0, 1));
                if (lim != 0 && $urandom_range(0, 9) != 0) src = SRC_W'($urandom_range(0, lim - 1));
                else src = SRC_W'($urandom_range(0, NUM_SOURCES_DEF - 1));
                case ($urandom_range(0, 3))
                    0: delay = $urandom_range(0, 4095);
                    1: delay = MIN_START - 2048 + $urandom_range(0, 4096);
                    2: delay = $urandom;
                    default: delay = $urandom_range(0, 1) ? CNT_MAX : MIN_START;
                endcase
                push_request(kind, src, delay, 1'b0, '0);
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);

        $display("checked %0d results: %0d produced, %0d consumed, %0d rejected requests",
                 results_seen, produced_reqs, consumed_reqs, rejected_reqs);
        $display("active source register written %0d times, %0d mismatches",
                 cfg_writes, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results pending", expected_stats.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
